FILE: hw/rtl/delimited_message_ring_buffer_assert.svh
// assertion macros shared by the checker of the message ring buffer
// depends on nothing; the including module must provide clk and arst_n
`ifndef DELIMITED_MESSAGE_RING_BUFFER_ASSERT_SVH
`define DELIMITED_MESSAGE_RING_BUFFER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define DMRB_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("dmrb assertion failed");

// condition holds in the cycle after the trigger
`define DMRB_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("dmrb assertion failed");

`endif

FILE: hw/rtl/dmrb_pkg.sv
// shared types and codes of the delimited message ring buffer
// no dependencies; used by dmrb_core, the top level and the checker
`default_nettype none

package dmrb_pkg;

	localparam int DEPTH_DEF   = 256;
	localparam int MAX_MSG_DEF = 64;

	// input modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_STORED  = 3'd0;
	localparam logic [2:0] KIND_DROPPED = 3'd1;
	localparam logic [2:0] KIND_MSG     = 3'd2;
	localparam logic [2:0] KIND_NO_MSG  = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	// configuration register indexes
	localparam logic CFG_END_FIRST  = 1'b0;
	localparam logic CFG_END_SECOND = 1'b1;

	localparam logic [7:0] END_FIRST_RST  = 8'd13;
	localparam logic [7:0] END_SECOND_RST = 8'd10;

	// one input word
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       first_of_packet;
		logic [7:0] packet_length;
	} dmrb_item_t;

	// one result word offered by the core
	typedef struct packed {
		logic       valid;
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic       last;
		logic       empty_message;
	} dmrb_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmrb_core.sv
// sequencer, byte ring memory, pointers and terminator compare unit
// depends on dmrb_pkg
`default_nettype none

module dmrb_core #(
	parameter int DEPTH   = dmrb_pkg::DEPTH_DEF,
	parameter int MAX_MSG = dmrb_pkg::MAX_MSG_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_take,
	input  wire dmrb_pkg::dmrb_item_t item,
	output logic                    idle,
	output dmrb_pkg::dmrb_res_t     res,
	input  wire logic               res_take,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = ((CW > 8) ? CW : 8) + 1;
	localparam int JW   = $clog2(MAX_MSG + 3);
	localparam int LW   = (MAX_MSG > 1) ? $clog2(MAX_MSG + 1) : 1;
	localparam int CMPW = (CW > JW) ? CW : JW;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_SCAN_RD  = 5'b00010,
		ST_SCAN_CHK = 5'b00100,
		ST_EMIT_RD  = 5'b01000,
		ST_EMIT_OUT = 5'b10000
	} dmrb_state_t;

	dmrb_state_t      state_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    bytes_q;
	logic [7:0]       pkts_q;
	logic             accepting_q;
	logic [7:0]       rem_q;
	logic [7:0]       end_first_q;
	logic [7:0]       end_second_q;

	logic [JW-1:0]    j_q;
	logic [AW-1:0]    scan_addr_q;
	logic [7:0]       prev_q;
	logic [AW-1:0]    emit_addr_q;
	logic [LW-1:0]    emit_cnt_q;

	logic [7:0]       ring_mem [DEPTH];
	logic [7:0]       rd_data_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [7:0]       len_eff;
	logic             first_ok;
	logic             cont_ok;
	logic             scan_stop;
	logic             hit;
	logic [CW-1:0]    bytes_freed;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		wrap_inc = (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	// write admission
	assign len_eff  = (item.packet_length == 8'd0) ? 8'd1 : item.packet_length;
	assign first_ok = (SW'(bytes_q) + SW'(len_eff)) < SW'(DEPTH);
	assign cont_ok  = accepting_q && (rem_q != 8'd0) && (bytes_q < CW'(DEPTH));
	assign wr_en    = (state_q == ST_IDLE) && item_take && (item.mode == dmrb_pkg::MODE_WRITE)
		&& (item.first_of_packet ? first_ok : cont_ok);

	// scan compare unit
	assign scan_stop = (CMPW'(j_q) >= CMPW'(bytes_q)) || (j_q == JW'(MAX_MSG + 2));
	assign hit = (j_q != '0) && (prev_q == end_first_q) && (rd_data_q == end_second_q);
	assign bytes_freed = bytes_q - CW'(j_q) - 1'b1;

	assign rd_en   = (state_q == ST_EMIT_RD) || ((state_q == ST_SCAN_RD) && !scan_stop);
	assign rd_addr = (state_q == ST_EMIT_RD) ? emit_addr_q : scan_addr_q;
	assign idle    = (state_q == ST_IDLE);

	// ring memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wp_q] <= item.data_byte;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// result word offered to the output stage
	always_comb begin
		res = '0;
		unique case (state_q)
			ST_IDLE: begin
				res.last = 1'b1;
				if (item_take) begin
					priority if (item.mode == dmrb_pkg::MODE_WRITE) begin
						res.valid = 1'b1;
						res.kind  = wr_en ? dmrb_pkg::KIND_STORED : dmrb_pkg::KIND_DROPPED;
					end else if (item.mode == dmrb_pkg::MODE_READ) begin
						res.valid = (pkts_q == 8'd0);
						res.kind  = dmrb_pkg::KIND_NO_MSG;
					end else if (item.mode == dmrb_pkg::MODE_CLEAR) begin
						res.valid = 1'b1;
						res.kind  = dmrb_pkg::KIND_CLEARED;
					end else begin
						res.valid = 1'b0;
					end
				end
			end
			ST_SCAN_RD: begin
				res.valid = scan_stop;
				res.kind  = dmrb_pkg::KIND_NO_MSG;
				res.last  = 1'b1;
			end
			ST_SCAN_CHK: begin
				res.valid         = hit && (j_q == JW'(1));
				res.kind          = dmrb_pkg::KIND_NO_MSG;
				res.last          = 1'b1;
				res.empty_message = 1'b1;
			end
			ST_EMIT_OUT: begin
				res.valid    = 1'b1;
				res.kind     = dmrb_pkg::KIND_MSG;
				res.out_byte = rd_data_q;
				res.last     = (emit_cnt_q == LW'(1));
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// sequencer and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			bytes_q      <= '0;
			pkts_q       <= '0;
			accepting_q  <= 1'b0;
			rem_q        <= '0;
			end_first_q  <= dmrb_pkg::END_FIRST_RST;
			end_second_q <= dmrb_pkg::END_SECOND_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dmrb_pkg::CFG_END_FIRST) begin
					end_first_q <= cfg_data;
				end else begin
					end_second_q <= cfg_data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						if (item.mode == dmrb_pkg::MODE_WRITE) begin
							if (wr_en) begin
								wp_q    <= wrap_inc(wp_q);
								bytes_q <= bytes_q + 1'b1;
							end
							if (item.first_of_packet) begin
								if (first_ok) begin
									if (pkts_q != 8'hFF) begin
										pkts_q <= pkts_q + 1'b1;
									end
									rem_q       <= len_eff - 1'b1;
									accepting_q <= (len_eff != 8'd1);
								end else begin
									rem_q       <= '0;
									accepting_q <= 1'b0;
								end
							end else if (cont_ok) begin
								rem_q       <= rem_q - 1'b1;
								accepting_q <= (rem_q != 8'd1);
							end
						end else if (item.mode == dmrb_pkg::MODE_READ) begin
							if (pkts_q != 8'd0) begin
								state_q <= ST_SCAN_RD;
							end
						end else if (item.mode == dmrb_pkg::MODE_CLEAR) begin
							wp_q        <= '0;
							rp_q        <= '0;
							bytes_q     <= '0;
							pkts_q      <= '0;
							accepting_q <= 1'b0;
							rem_q       <= '0;
						end
					end
				end
				ST_SCAN_RD: begin
					if (!scan_stop) begin
						state_q <= ST_SCAN_CHK;
					end else if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						if (j_q == JW'(1)) begin
							if (res_take) begin
								rp_q    <= wrap_inc(scan_addr_q);
								bytes_q <= bytes_freed;
								pkts_q  <= pkts_q - 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							rp_q    <= wrap_inc(scan_addr_q);
							bytes_q <= bytes_freed;
							pkts_q  <= pkts_q - 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (res_take) begin
						state_q <= (emit_cnt_q == LW'(1)) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan and emit working registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item_take) begin
			j_q         <= '0;
			scan_addr_q <= rp_q;
		end
		if ((state_q == ST_SCAN_CHK) && !hit) begin
			prev_q      <= rd_data_q;
			j_q         <= j_q + 1'b1;
			scan_addr_q <= wrap_inc(scan_addr_q);
		end
		if ((state_q == ST_SCAN_CHK) && hit) begin
			emit_addr_q <= rp_q;
			emit_cnt_q  <= LW'(j_q - 1'b1);
		end
		if ((state_q == ST_EMIT_OUT) && res_take) begin
			emit_addr_q <= wrap_inc(emit_addr_q);
			emit_cnt_q  <= emit_cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/delimited_message_ring_buffer.sv
// Byte ring buffer for length-judged packets with terminator-delimited message readout.
// Write and clear words have their result offered the next cycle.
// A read scans stored bytes, each read through the one ring memory read port, then compared,
// up to MAX_MSG+2 bytes, then reads and emits each message byte while the output is taken.
// Throughput: one word at a time; the next word is accepted once the read sequence ends.
// Reset clears pointers and counts and presets the terminators; ring memory is not cleared.
`default_nettype none

module delimited_message_ring_buffer #(
	parameter int DEPTH   = dmrb_pkg::DEPTH_DEF,
	parameter int MAX_MSG = dmrb_pkg::MAX_MSG_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // data_byte[7:0], packet_length[15:8]
	input  wire logic [2:0]  s_tuser,   // mode[1:0], first_of_packet[2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic [3:0]       m_tuser,   // kind[2:0], empty_message[3]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	dmrb_pkg::dmrb_item_t item;
	dmrb_pkg::dmrb_res_t  res;
	logic                 core_idle;
	logic                 slot_free;
	logic                 item_take;
	logic                 res_take;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic [3:0]           out_user_q;
	logic                 out_last_q;

	// unpack the input word
	assign item.mode            = s_tuser[1:0];
	assign item.first_of_packet = s_tuser[2];
	assign item.data_byte       = s_tdata[7:0];
	assign item.packet_length   = s_tdata[15:8];

	// handshakes
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = core_idle && slot_free;
	assign item_take = s_tvalid && s_tready;
	assign res_take  = res.valid && slot_free;

	dmrb_core #(
		.DEPTH   (DEPTH),
		.MAX_MSG (MAX_MSG)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_take (item_take),
		.item      (item),
		.idle      (core_idle),
		.res       (res),
		.res_take  (res_take),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_byte_q <= res.out_byte;
			out_user_q <= {res.empty_message, res.kind};
			out_last_q <= res.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dmrb_checker.sv
// port-level checks of the delimited message ring buffer, bound to the top level
// depends on dmrb_pkg and delimited_message_ring_buffer_assert.svh
`default_nettype none

`include "delimited_message_ring_buffer_assert.svh"

module dmrb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [3:0] m_tuser,
	input wire logic       m_tlast
);

	// a new word is only taken when the output register can hold its result
	`DMRB_ASSERT_SAME(a_ready_needs_slot, s_tready, !m_tvalid || m_tready)

	// results other than message bytes carry a zero byte and end their word
	`DMRB_ASSERT_SAME(a_nonmsg_zero_last, m_tvalid && (m_tuser[2:0] != dmrb_pkg::KIND_MSG),
		(m_tdata == 8'd0) && m_tlast)

	// empty message flag only comes with a no-message result
	`DMRB_ASSERT_SAME(a_empty_kind, m_tvalid && m_tuser[3],
		m_tuser[2:0] == dmrb_pkg::KIND_NO_MSG)

	// a stalled result holds
	`DMRB_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind delimited_message_ring_buffer dmrb_checker u_dmrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/tb_delimited_message_ring_buffer.sv
// testbench of delimited_message_ring_buffer: packets go in as write words, messages
// come back out; every result word is checked against a predictor kept in this file
// depends on dmrb_pkg and the delimited_message_ring_buffer top level
`default_nettype none

module tb_delimited_message_ring_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	// the block ignores this mode and gives no result
	localparam logic [1:0] MODE_NOP = 2'd3;
	// a read may scan MAX_MSG+2 bytes before it can finish
	localparam int DRAIN_CYCLES = 2 * (dmrb_pkg::MAX_MSG_DEF + 2) + 16;
	localparam int MAX_GAP      = 18;
	localparam int N_SCRIPT     = 26;
	localparam int N_PHASES     = 6;

	// one result word as it should leave the block
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic       last;
		logic       empty_message;
	} ring_word_t;

	// one row of the directed script; want_* only used when pinned is set
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       first;
		logic [7:0] plen;
		logic       pinned;
		logic [2:0] want_kind;
		logic       want_empty;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // data_byte[7:0], packet_length[15:8]
	logic [2:0]  s_tuser = '0;    // mode[1:0], first_of_packet[2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // out_byte[7:0]
	logic [3:0]  m_tuser;         // kind[2:0], empty_message[3]
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = dmrb_pkg::CFG_END_FIRST;
	logic [7:0]  cfg_data = '0;

	delimited_message_ring_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state of the ring
	logic [7:0]  ring_mem [dmrb_pkg::DEPTH_DEF];
	int unsigned wr_ptr, rd_ptr, fill, pkt_count, pkt_left;
	logic        pkt_open;
	logic [7:0]  term_first = dmrb_pkg::END_FIRST_RST;
	logic [7:0]  term_second = dmrb_pkg::END_SECOND_RST;

	ring_word_t  owed_words [$];
	int          bad_words = 0;
	bit          idle_on = 1'b0;
	bit          tx_up = 1'b0;
	int          rx_hold = 0;
	script_row_t script [N_SCRIPT];

	function automatic void owe(input logic [2:0] kind, input logic [7:0] b,
			input logic last, input logic empty_message);
		ring_word_t w;
		w.kind          = kind;
		w.out_byte      = b;
		w.last          = last;
		w.empty_message = empty_message;
		owed_words.push_back(w);
	endfunction

	function automatic void empty_ring();
		wr_ptr    = 0;
		rd_ptr    = 0;
		fill      = 0;
		pkt_count = 0;
		pkt_left  = 0;
		pkt_open  = 1'b0;
	endfunction

	function automatic void push_ring(input logic [7:0] b);
		ring_mem[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1) % dmrb_pkg::DEPTH_DEF;
		fill++;
	endfunction

	// expected result words of one accepted input word
	function automatic void predict_ring(input logic [1:0] mode, input logic [7:0] b,
			input logic first, input logic [7:0] plen);
		int unsigned span, msg_len, i;
		bit          took, found;
		took    = 1'b0;
		found   = 1'b0;
		msg_len = 0;
		case (mode)
			dmrb_pkg::MODE_WRITE: begin
				if (first) begin
					span = (plen == 0) ? 1 : plen;
					if (dmrb_pkg::DEPTH_DEF - fill > span) begin
						push_ring(b);
						took = 1'b1;
						if (pkt_count < 255)
							pkt_count++;
						pkt_left = span - 1;
						pkt_open = pkt_left > 0;
					end else begin
						pkt_open = 1'b0;
						pkt_left = 0;
					end
				end else if (pkt_open && pkt_left > 0 && fill < dmrb_pkg::DEPTH_DEF) begin
					push_ring(b);
					took = 1'b1;
					pkt_left--;
					pkt_open = pkt_left > 0;
				end
				owe(took ? dmrb_pkg::KIND_STORED : dmrb_pkg::KIND_DROPPED, 8'h00, 1'b1, 1'b0);
			end
			dmrb_pkg::MODE_READ: begin
				if (pkt_count == 0) begin
					owe(dmrb_pkg::KIND_NO_MSG, 8'h00, 1'b1, 1'b0);
				end else begin
					// terminator must start within MAX_MSG of the oldest byte
					for (i = 0; i <= dmrb_pkg::MAX_MSG_DEF && !found && i + 1 < fill; i++) begin
						if (ring_mem[(rd_ptr + i) % dmrb_pkg::DEPTH_DEF] == term_first &&
								ring_mem[(rd_ptr + i + 1) % dmrb_pkg::DEPTH_DEF]
								== term_second) begin
							found   = 1'b1;
							msg_len = i;
						end
					end
					if (!found) begin
						owe(dmrb_pkg::KIND_NO_MSG, 8'h00, 1'b1, 1'b0);
					end else begin
						if (msg_len == 0)
							owe(dmrb_pkg::KIND_NO_MSG, 8'h00, 1'b1, 1'b1);
						for (i = 0; i < msg_len; i++)
							owe(dmrb_pkg::KIND_MSG, ring_mem[(rd_ptr + i) % dmrb_pkg::DEPTH_DEF],
								i + 1 == msg_len, 1'b0);
						rd_ptr = (rd_ptr + msg_len + 2) % dmrb_pkg::DEPTH_DEF;
						fill -= msg_len + 2;
						pkt_count--;
					end
				end
			end
			dmrb_pkg::MODE_CLEAR: begin
				empty_ring();
				owe(dmrb_pkg::KIND_CLEARED, 8'h00, 1'b1, 1'b0);
			end
			default: ;
		endcase
	endfunction

	// compare one result word with the oldest expectation
	function automatic void check_word();
		ring_word_t got, want;
		got.kind          = m_tuser[2:0];
		got.out_byte      = m_tdata;
		got.last          = m_tlast;
		got.empty_message = m_tuser[3];
		if (owed_words.size() == 0) begin
			bad_words++;
			if (bad_words <= 10)
				$display("unexpected word: kind %0d byte %02h last %0d empty %0d",
					got.kind, got.out_byte, got.last, got.empty_message);
		end else begin
			want = owed_words.pop_front();
			if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
					got.last !== want.last || got.empty_message !== want.empty_message) begin
				bad_words++;
				if (bad_words <= 10)
					$display("mismatch: expected kind %0d byte %02h last %0d empty %0d, %s",
						want.kind, want.out_byte, want.last, want.empty_message,
						$sformatf("got kind %0d byte %02h last %0d empty %0d",
							got.kind, got.out_byte, got.last, got.empty_message));
			end
		end
	endfunction

	// result side: take words, stall a random number of cycles after each
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_word();
				rx_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
				if (rx_hold != 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (rx_hold <= 1)
					m_tready <= 1'b1;
				rx_hold = rx_hold - 1;
			end
		end
	end

	// offer one input word and wait for it to be taken
	task automatic send_word(input logic [1:0] mode, input logic [7:0] b,
			input logic first, input logic [7:0] plen, input logic pinned,
			input logic [2:0] want_kind, input logic want_empty);
		int unsigned n_owed;
		s_tvalid <= 1'b1;
		s_tdata  <= {plen, b};
		s_tuser  <= {first, mode};
		tx_up = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		n_owed = owed_words.size();
		predict_ring(mode, b, first, plen);
		// rows with a typed result replace what the predictor produced
		if (pinned) begin
			while (owed_words.size() > n_owed)
				void'(owed_words.pop_back());
			owe(want_kind, 8'h00, 1'b1, want_empty);
		end
	endtask

	task automatic send_plain(input logic [1:0] mode, input logic [7:0] b,
			input logic first, input logic [7:0] plen);
		int gap;
		send_word(mode, b, first, plen, 1'b0, dmrb_pkg::KIND_STORED, 1'b0);
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			tx_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, wait for all results and for a read that gives none to finish
	task automatic settle();
		if (tx_up) begin
			s_tvalid <= 1'b0;
			tx_up = 1'b0;
		end
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_terminator(input logic [7:0] first_b, input logic [7:0] second_b);
		cfg_we    <= 1'b1;
		cfg_index <= dmrb_pkg::CFG_END_FIRST;
		cfg_data  <= first_b;
		@(posedge clk);
		cfg_index <= dmrb_pkg::CFG_END_SECOND;
		cfg_data  <= second_b;
		@(posedge clk);
		cfg_we <= 1'b0;
		term_first  = first_b;
		term_second = second_b;
	endtask

	// one packet of whole messages, now and then with a wrong length
	task automatic send_packet(inout int count);
		logic [7:0] pkt [$];
		int         n_msg, body, declared, k, j;
		n_msg = ($urandom_range(0, 9) == 0) ? 2 : 1;
		for (k = 0; k < n_msg; k++) begin
			case ($urandom_range(0, 19))
				0:       body = $urandom_range(60, 70);
				1, 2, 3: body = $urandom_range(9, 30);
				default: body = $urandom_range(0, 8);
			endcase
			for (j = 0; j < body; j++)
				pkt.push_back(8'($urandom_range(0, 255)));
			pkt.push_back(term_first);
			pkt.push_back(term_second);
		end
		declared = pkt.size();
		case ($urandom_range(0, 9))
			0: declared = declared + $urandom_range(1, 5);
			1: declared = declared - $urandom_range(1, 3);
			default: ;
		endcase
		if (declared > 255)
			declared = 255;
		if (declared < 0)
			declared = 0;
		for (j = 0; j < pkt.size(); j++)
			send_plain(dmrb_pkg::MODE_WRITE, pkt[j], j == 0,
				(j == 0) ? 8'(declared) : 8'($urandom_range(0, 255)));
		count += pkt.size();
	endtask

	// random traffic under one terminator setting
	task automatic run_phase(input int target, input int read_pct);
		int   count, pick;
		logic [1:0] mode;
		count = 0;
		while (count < target) begin
			idle_on = $urandom_range(0, 4) != 0;
			pick = $urandom_range(0, 99);
			if (pick < read_pct) begin
				send_plain(dmrb_pkg::MODE_READ, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				count++;
			end else if (pick < 88) begin
				send_packet(count);
			end else if (pick < 90) begin
				send_plain(dmrb_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				count++;
			end else begin
				// noise: any mode, any content
				mode = 2'($urandom_range(0, 3));
				send_plain(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
				if (mode != MODE_NOP)
					count++;
			end
		end
	endtask

	initial begin
		logic [7:0] ph_first  [N_PHASES];
		logic [7:0] ph_second [N_PHASES];
		int         ph_read   [N_PHASES];
		int         r, p;

		script = '{
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b1, dmrb_pkg::KIND_NO_MSG,  1'b0},
			'{MODE_NOP,             8'hC3, 1'b1, 8'd9,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			// length zero counts as one
			'{dmrb_pkg::MODE_WRITE, 8'h41, 1'b1, 8'd0,   1'b1, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h48, 1'b1, 8'd4,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h69, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h0D, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h0A, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			// terminator right at the oldest byte
			'{dmrb_pkg::MODE_WRITE, 8'h0D, 1'b1, 8'd2,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h0A, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b1, dmrb_pkg::KIND_NO_MSG,  1'b1},
			// packet without a terminator
			'{dmrb_pkg::MODE_WRITE, 8'hFF, 1'b1, 8'd3,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h00, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h80, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b1, dmrb_pkg::KIND_NO_MSG,  1'b0},
			// new packet starts before the old one is complete
			'{dmrb_pkg::MODE_WRITE, 8'h55, 1'b1, 8'd200, 1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h01, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h0D, 1'b1, 8'd3,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h0A, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'h7F, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			// byte past the end of the packet
			'{dmrb_pkg::MODE_WRITE, 8'h33, 1'b0, 8'd255, 1'b1, dmrb_pkg::KIND_DROPPED, 1'b0},
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b0, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_CLEAR, 8'h00, 1'b0, 8'd0,   1'b1, dmrb_pkg::KIND_CLEARED, 1'b0},
			// largest length fits only into an empty ring
			'{dmrb_pkg::MODE_WRITE, 8'hAA, 1'b1, 8'd255, 1'b1, dmrb_pkg::KIND_STORED,  1'b0},
			'{dmrb_pkg::MODE_WRITE, 8'hAA, 1'b1, 8'd255, 1'b1, dmrb_pkg::KIND_DROPPED, 1'b0},
			'{dmrb_pkg::MODE_READ,  8'h00, 1'b0, 8'd0,   1'b1, dmrb_pkg::KIND_NO_MSG,  1'b0}
		};
		ph_first  = '{8'd13, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
		ph_second = '{8'd10, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
		ph_read   = '{25, 25, 8, 25, 30, 20};
		ph_first[5]  = 8'($urandom_range(0, 255));
		ph_second[5] = 8'($urandom_range(0, 255));
		empty_ring();

		// reset
		repeat (7) @(posedge clk);
		arst_n   <= 1'b1;
		m_tready <= 1'b1;
		@(posedge clk);

		// directed script
		idle_on = 1'b1;
		for (r = 0; r < N_SCRIPT; r++) begin
			send_word(script[r].mode, script[r].data_byte, script[r].first, script[r].plen,
				script[r].pinned, script[r].want_kind, script[r].want_empty);
			if ($urandom_range(0, 1) != 0) begin
				s_tvalid <= 1'b0;
				tx_up = 1'b0;
				repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			end
		end

		// random phases, one terminator setting each
		for (p = 0; p < N_PHASES; p++) begin
			settle();
			set_terminator(ph_first[p], ph_second[p]);
			run_phase(42, ph_read[p]);
		end
		settle();

		if (bad_words == 0 && owed_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
